// File: rtl/blr_pkg.sv
// Shared constants and controller/datapath interface types for the byte lane register block.
package blr_pkg;

    // Largest register block in bytes; the configured size is clipped to this.
    localparam int MAX_BLOCK_BYTES = 1024;
    localparam int WORD_COUNT      = (MAX_BLOCK_BYTES + 3) / 4;
    localparam int WORD_AW         = $clog2(WORD_COUNT);

    // Field widths of the stream items and of the size register.
    localparam int OFFSET_W   = 16;
    localparam int WIDTH_W    = 4;
    localparam int DATA_W     = 64;
    localparam int WORD_W     = 32;
    localparam int BOUND_W    = 11;
    localparam int SUM_W      = OFFSET_W + 1;
    localparam int S_TDATA_W  = 88;
    localparam int M_TDATA_W  = 64;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    // Word counter: an access touches at most three words.
    localparam int WCNT_W = 2;

    localparam logic [BOUND_W-1:0] BLOCK_BYTES_RST = BOUND_W'(1024);
    localparam logic [SUM_W-1:0]   MAX_BOUND       = SUM_W'(MAX_BLOCK_BYTES);

    // Register index of the size register.
    localparam logic REG_BLOCK_BYTES = 1'b0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the incoming beat and run the access check
        logic rd_en;     // read the current word from the register memory
        logic merge;     // merge (write) or gather (read) the current word; a merged word is written back
        logic out_load;  // move the finished result into the output register
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fault;     // captured access failed its check
        logic last_word; // current word is the last one the access touches
        logic out_free;  // output register can take a result this cycle
    } t_dp_sts;

endpackage

// File: rtl/byte_lane_register_block.sv
// Top level of the byte lane register block: stream ports, size register port and sequencer.
//
// The block holds a bank of 32-bit registers addressed by byte, little-endian.
// Each beat on the slave stream is one bus access: tuser says read or write,
// tdata carries the byte offset, the access width (1, 2, 4 or 8 bytes) and the
// write data. An access may start at any byte and may touch up to three words;
// a write changes only the bytes it covers. Each access returns exactly one
// beat on the master stream with the read data (zero for a write) and a fault
// flag in tuser. A fault comes from an unsupported width or from an access
// that runs past the block size; then nothing is written and the data is zero.
// The block size register sits at address 0 of the APB port and bounds the
// access check; the user must write it only while no access is in flight, as
// the block itself does not enforce this. Accesses run one at a time through
// a sequencer that reads, merges and writes back one word at a time over a
// single memory port and then loads the result into the output register; the
// next beat is accepted in the cycle after the result is loaded. A faulting
// access skips the memory and has its result loaded directly. When the
// master side stalls, the result waits in the output register and the next
// access waits in its final step. Synchronous active-low reset zeroes all
// registers via per-word valid bits, sets the size to 1024, empties the output.
module byte_lane_register_block (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Slave stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // offset[15:0], access_bytes[19:16], write_data[83:20], zero fill[87:84]
    input  logic [blr_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // is_write[0]
    input  logic                                s_axis_tuser,
    // Master stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // read_data[63:0]
    output logic [blr_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    // fault[0]
    output logic                                m_axis_tuser,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [blr_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [blr_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [blr_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import blr_pkg::*;

    t_ctl_cmd            cmd;
    t_dp_sts             sts;
    logic [BOUND_W-1:0]  r_block_bytes;
    logic                cfg_wr;

    // The size register decodes on word address; byte lanes within it alias.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[CFG_ADDR_W-1] == REG_BLOCK_BYTES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes <= BLOCK_BYTES_RST;
        end else if (cfg_wr) begin
            r_block_bytes <= pwdata[BOUND_W-1:0];
        end
    end

    assign prdata = (paddr[CFG_ADDR_W-1] == REG_BLOCK_BYTES) ?
                    {{(CFG_DATA_W-BOUND_W){1'b0}}, r_block_bytes} : '0;

    blr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    blr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_in_is_write (s_axis_tuser),
        .i_in_offset   (s_axis_tdata[OFFSET_W-1:0]),
        .i_in_width    (s_axis_tdata[OFFSET_W +: WIDTH_W]),
        .i_in_wdata    (s_axis_tdata[OFFSET_W+WIDTH_W +: DATA_W]),
        .i_block_bytes (r_block_bytes),
        .i_out_ready   (m_axis_tready),
        .o_sts         (sts),
        .o_out_valid   (m_axis_tvalid),
        .o_out_data    (m_axis_tdata),
        .o_out_fault   (m_axis_tuser)
    );

`ifndef SYNTHESIS
    // Only one access is in flight: an accepted beat closes the input.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an access is in flight");

    // A faulting access never reaches the memory.
    a_fault_no_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.merge |-> !sts.fault)
        else $error("merge issued for a faulting access");

    // Each word read is followed by its merge.
    a_read_then_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd_en |=> cmd.merge)
        else $error("word read not followed by merge");

    // A loaded result shows up on the master stream.
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> m_axis_tvalid)
        else $error("result loaded but not presented");
`endif

endmodule

// File: rtl/blr_ctrl.sv
// Sequencer for the byte lane register block: one access at a time, word by word.
module blr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  blr_pkg::t_dp_sts  i_sts,
    output logic              o_in_ready,
    output blr_pkg::t_ctl_cmd o_cmd
);
    import blr_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_MERGE  = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_READ;
                end
            end
            ST_READ: begin
                // A failed check skips the memory entirely.
                if (i_sts.fault) begin
                    n_state = ST_RESULT;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = ST_MERGE;
                end
            end
            ST_MERGE: begin
                o_cmd.merge = 1'b1;
                n_state     = i_sts.last_word ? ST_RESULT : ST_READ;
            end
            ST_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/blr_dp.sv
// Datapath of the byte lane register block: access check, word memory, byte merge and result register.
module blr_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  blr_pkg::t_ctl_cmd                i_cmd,
    input  logic                             i_in_is_write,
    input  logic [blr_pkg::OFFSET_W-1:0]     i_in_offset,
    input  logic [blr_pkg::WIDTH_W-1:0]      i_in_width,
    input  logic [blr_pkg::DATA_W-1:0]       i_in_wdata,
    input  logic [blr_pkg::BOUND_W-1:0]      i_block_bytes,
    input  logic                             i_out_ready,
    output blr_pkg::t_dp_sts                 o_sts,
    output logic                             o_out_valid,
    output logic [blr_pkg::DATA_W-1:0]       o_out_data,
    output logic                             o_out_fault
);
    import blr_pkg::*;

    // Captured access.
    logic                r_is_write;
    logic [1:0]          r_off_lo;
    logic [WORD_AW-1:0]  r_base;
    logic [WIDTH_W-1:0]  r_width;
    logic [DATA_W-1:0]   r_wdata;
    logic                r_fault;
    logic [WCNT_W-1:0]   r_last_k;
    logic [WCNT_W-1:0]   r_k;
    logic [DATA_W-1:0]   r_rdata;
    logic [DATA_W-1:0]   n_rdata;

    // Register memory; a word never written reads as zero through its valid bit.
    logic [WORD_W-1:0]     mem [WORD_COUNT];
    logic [WORD_COUNT-1:0] r_valid;
    logic [WORD_W-1:0]     r_mem_q;
    logic                  r_mem_v;
    logic [WORD_W-1:0]     n_word;
    logic [WORD_W-1:0]     old_word;
    logic [WORD_AW-1:0]    word_addr;

    // Result register.
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_data;
    logic                r_out_fault;

    // Access check on the incoming beat.
    logic [SUM_W-1:0]    bound;
    logic [SUM_W-1:0]    end_addr;
    logic                width_ok;
    logic                in_fault;
    logic [4:0]          span;

    always_comb begin
        bound    = ({6'b0, i_block_bytes} > MAX_BOUND) ? MAX_BOUND : {6'b0, i_block_bytes};
        end_addr = {1'b0, i_in_offset} + {13'b0, i_in_width};
        width_ok = (i_in_width == 4'd1) || (i_in_width == 4'd2) ||
                   (i_in_width == 4'd4) || (i_in_width == 4'd8);
        in_fault = !width_ok || (end_addr > bound);
        // Index of the last touched byte relative to the first word; bits [3:2] give the last word.
        span     = {3'b0, i_in_offset[1:0]} + {1'b0, i_in_width} - 5'd1;
    end

    assign word_addr = r_base + {{(WORD_AW-WCNT_W){1'b0}}, r_k};
    assign old_word  = r_mem_v ? r_mem_q : '0;

    // Per-lane merge of the current word: lanes are independent.
    always_comb begin
        logic [3:0] pos;
        logic [3:0] rel;
        logic       cov;
        n_word  = old_word;
        n_rdata = r_rdata;
        for (int l = 0; l < 4; l++) begin
            pos = {r_k, 2'(l)};
            rel = pos - {2'b0, r_off_lo};
            cov = (pos >= {2'b0, r_off_lo}) && (rel < r_width);
            if (cov) begin
                if (r_is_write) begin
                    n_word[l*8 +: 8] = r_wdata[{rel[2:0], 3'b000} +: 8];
                end else begin
                    n_rdata[{rel[2:0], 3'b000} +: 8] = old_word[l*8 +: 8];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_write <= i_in_is_write;
            r_off_lo   <= i_in_offset[1:0];
            r_base     <= i_in_offset[WORD_AW+1:2];
            r_width    <= i_in_width;
            r_wdata    <= i_in_wdata;
            r_last_k   <= span[3:2];
            r_rdata    <= '0;
        end else if (i_cmd.merge) begin
            r_rdata    <= n_rdata;
        end
        if (i_cmd.rd_en) begin
            r_mem_q <= mem[word_addr];
            r_mem_v <= r_valid[word_addr];
        end
        if (i_cmd.merge && r_is_write) begin
            mem[word_addr] <= n_word;
        end
        if (i_cmd.out_load) begin
            r_out_data  <= (r_is_write || r_fault) ? '0 : r_rdata;
            r_out_fault <= r_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault     <= 1'b0;
            r_k         <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_fault <= in_fault;
                r_k     <= '0;
            end else if (i_cmd.merge && (r_k != r_last_k)) begin
                r_k <= r_k + 2'd1;
            end
            if (i_cmd.merge && r_is_write) begin
                r_valid[word_addr] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.fault     = r_fault;
        o_sts.last_word = (r_k == r_last_k);
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_fault = r_out_fault;

endmodule
